### hw/rtl/amr_pkg.sv
// amr_pkg: shared types, operation and status codes for the reachability unit
// no dependencies
`timescale 1ns / 1ps
package amr_pkg;

  localparam int unsigned MaxVerticesDefault = 16;
  localparam int unsigned WeightBitsDefault  = 16;

  typedef enum logic [2:0] {
    OP_ADD          = 3'd0,
    OP_SET          = 3'd1,
    OP_CLEAR        = 3'd2,
    OP_QUERY        = 3'd3,
    OP_CLEAR_VERTEX = 3'd4,
    OP_REACH        = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic [1:0] RegDirected = 2'd0;

  typedef struct packed {
    logic [2:0]         operation;
    logic [3:0]         source_vertex;
    logic [3:0]         target_vertex;
    logic signed [15:0] edge_weight;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] weight_read;
    logic               edge_present;
    logic               is_neighbour;
    logic [15:0]        reach_mask;
    logic [4:0]         vertex_total;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE1,
    S_WRITE2,
    S_QREAD,
    S_QWAIT,
    S_SWEEP,
    S_POP,
    S_ROWRD,
    S_ROWWAIT,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

### hw/rtl/amr_matrix_mem.sv
// amr_matrix_mem: flattened weight matrix with a registered read
// no dependencies
`timescale 1ns / 1ps
module amr_matrix_mem #(
  parameter int unsigned Depth      = 256,
  parameter int unsigned WeightBits = 16,
  parameter int unsigned AddrBits   = 8
) (
  input  logic                  clk_i,
  input  logic                  wr_i,
  input  logic [AddrBits-1:0]   waddr_i,
  input  logic [WeightBits-1:0] wdata_i,
  input  logic                  rd_i,
  input  logic [AddrBits-1:0]   raddr_i,
  output logic [WeightBits-1:0] rdata_o
);
  logic [WeightBits-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

### hw/rtl/amr_stack.sv
// amr_stack: walk stack memory, registered read
// no dependencies
`timescale 1ns / 1ps
module amr_stack #(
  parameter int unsigned Depth    = 16,
  parameter int unsigned AddrBits = 4,
  parameter int unsigned DataBits = 4
) (
  input  logic                clk_i,
  input  logic                push_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataBits-1:0] rdata_o
);
  logic [DataBits-1:0] stk_q [Depth];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      stk_q[waddr_i] <= wdata_i;
    end
    rdata_o <= stk_q[raddr_i];
  end
endmodule

### hw/rtl/adjacency_matrix_reachability_unit.sv
// adjacency_matrix_reachability_unit: top level, sequencer around the matrix memory
// depends on amr_pkg, amr_matrix_mem, amr_stack
`timescale 1ns / 1ps
//
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+------------------------
// req       | in        | req_valid_i/o    | amr_pkg::req_t
// rsp       | out       | rsp_valid_o/i    | amr_pkg::rsp_t
// apb       | in        | psel/penable     | directed_mode at 0x0
//
// from acceptance to a valid result: set and clear write one entry in directed mode
// and its mirror as well otherwise; query does one registered read; add vertex
// and clear vertex sweep one row and one column; reach scans the live columns of
// each popped vertex's row; a rejected transaction goes straight to the result
// the matrix is not cleared at reset: add vertex zeroes the new row and column
// before any read can reach them
// one transaction at a time: a pending result holds req_ready_o low until taken
module adjacency_matrix_reachability_unit #(
  parameter int unsigned MaxVertices = amr_pkg::MaxVerticesDefault,
  parameter int unsigned WeightBits  = amr_pkg::WeightBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  amr_pkg::req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output amr_pkg::rsp_t rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import amr_pkg::*;

  localparam int unsigned VBits   = $clog2(MaxVertices);
  localparam int unsigned CBits   = $clog2(MaxVertices + 1);
  localparam int unsigned ABits   = 2 * VBits;
  localparam int unsigned Entries = 2 ** ABits;

  // configuration
  logic directed_q;
  assign pready = 1'b1;
  assign prdata = {31'd0, directed_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == RegDirected) begin
      directed_q <= pwdata[0];
    end
  end

  state_e state_q, state_d;
  req_t   req_q;
  logic [CBits-1:0] count_q, count_d;
  logic [CBits-1:0] idx_q, idx_d;     // sweep or scan column
  logic             phase_q, phase_d; // row then column in sweeps
  logic [VBits-1:0] cur_q, cur_d;     // row under walk
  logic [VBits:0]   sp_q, sp_d;
  logic [MaxVertices-1:0] vis_q, vis_d;
  rsp_t rsp_q, rsp_d;
  logic rspv_q, rspv_d;
  logic rd_pend_q, rd_pend_d;

  // memory ports
  logic                  m_wr, m_rd;
  logic [ABits-1:0]      m_waddr, m_raddr;
  logic [WeightBits-1:0] m_wdata, m_rdata, w_eff;
  logic                  s_push;
  logic [VBits-1:0]      s_waddr, s_raddr;
  logic [VBits-1:0]      s_wdata, s_rdata;

  amr_matrix_mem #(.Depth(Entries), .WeightBits(WeightBits), .AddrBits(ABits)) u_mem (
    .clk_i, .wr_i(m_wr), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .rd_i(m_rd), .raddr_i(m_raddr), .rdata_o(m_rdata)
  );
  amr_stack #(.Depth(MaxVertices), .AddrBits(VBits), .DataBits(VBits)) u_stk (
    .clk_i, .push_i(s_push), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // only entries inside the live square are read, and those were all swept
  assign w_eff = m_rdata;

  logic [VBits-1:0] src_v, dst_v;
  logic             src_ok, dst_ok, w_pos;
  logic [15:0]      w16;
  logic [WeightBits-1:0] wr_weight;
  assign src_v  = VBits'(req_q.source_vertex);
  assign dst_v  = VBits'(req_q.target_vertex);
  assign src_ok = 32'(req_q.source_vertex) < 32'(count_q);
  assign dst_ok = 32'(req_q.target_vertex) < 32'(count_q);
  assign w_pos  = !w_eff[WeightBits-1] && (w_eff != '0);
  assign w16    = 16'($signed(w_eff));
  assign wr_weight = (req_q.operation == OP_SET) ? WeightBits'(req_q.edge_weight) : '0;

  logic [15:0] vis16;
  always_comb begin
    vis16 = '0;
    for (int k = 0; k < 16; k++) begin
      if (k < MaxVertices) vis16[k] = vis_q[k];
    end
  end

  assign req_ready_o = (state_q == S_IDLE) && !rspv_q;
  assign rsp_valid_o = rspv_q;
  assign rsp_o       = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_valid_i && req_ready_o) state_d = S_DECODE;
      S_DECODE: begin
        case (req_q.operation)
          OP_ADD:          state_d = (count_q >= CBits'(MaxVertices)) ? S_DONE : S_SWEEP;
          OP_SET, OP_CLEAR: state_d = (src_ok && dst_ok) ? S_WRITE1 : S_DONE;
          OP_QUERY:        state_d = (src_ok && dst_ok) ? S_QREAD : S_DONE;
          OP_CLEAR_VERTEX: state_d = src_ok ? S_SWEEP : S_DONE;
          OP_REACH:        state_d = src_ok ? S_POP : S_DONE;
          default:         state_d = S_DONE;
        endcase
      end
      S_WRITE1: state_d = directed_q ? S_DONE : S_WRITE2;
      S_WRITE2: state_d = S_DONE;
      S_QREAD:  state_d = S_QWAIT;
      S_QWAIT:  state_d = S_DONE;
      S_SWEEP:  if (phase_q && idx_q == CBits'(MaxVertices - 1)) state_d = S_DONE;
      S_POP:    state_d = (sp_q == '0) ? S_DONE : S_ROWRD;
      S_ROWRD:  state_d = S_ROWWAIT;
      S_ROWWAIT: state_d = S_SCAN;
      S_SCAN:   if (!rd_pend_q) state_d = S_POP;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d = count_q; idx_d = idx_q; phase_d = phase_q; cur_d = cur_q;
    sp_d = sp_q; vis_d = vis_q; rsp_d = rsp_q; rspv_d = rspv_q; rd_pend_d = 1'b0;
    m_wr = 1'b0; m_rd = 1'b0; m_waddr = '0; m_raddr = '0; m_wdata = '0;
    s_push = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    if (rspv_q && rsp_ready_i) rspv_d = 1'b0;
    case (state_q)
      S_DECODE: begin
        rsp_d = '0;
        idx_d = '0; phase_d = 1'b0;
        if (req_q.operation == OP_REACH) begin
          vis_d = '0;
          vis_d[src_v] = 1'b1;
          s_push = 1'b1; s_waddr = '0; s_wdata = src_v;
          sp_d = (VBits+1)'(1);
        end
      end
      S_WRITE1: begin
        m_wr = 1'b1; m_waddr = {src_v, dst_v}; m_wdata = wr_weight;
      end
      S_WRITE2: begin
        m_wr = 1'b1; m_waddr = {dst_v, src_v}; m_wdata = wr_weight;
      end
      S_QREAD: begin
        m_rd = 1'b1; m_raddr = {src_v, dst_v};
      end
      S_QWAIT: begin
        rsp_d.weight_read  = w16;
        rsp_d.edge_present = (w_eff != '0);
        rsp_d.is_neighbour = w_pos;
      end
      S_SWEEP: begin
        // row pass then column pass over the vertex being cleared
        m_wr = 1'b1; m_wdata = '0;
        if (req_q.operation == OP_ADD) begin
          m_waddr = phase_q ? {VBits'(idx_q), VBits'(count_q)} : {VBits'(count_q), VBits'(idx_q)};
        end else begin
          m_waddr = phase_q ? {VBits'(idx_q), src_v} : {src_v, VBits'(idx_q)};
        end
        if (idx_q == CBits'(MaxVertices - 1)) begin
          idx_d = '0; phase_d = 1'b1;
          if (phase_q && req_q.operation == OP_ADD) count_d = count_q + 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_POP: begin
        if (sp_q != '0) begin
          s_raddr = VBits'(sp_q - 1'b1);
          sp_d = sp_q - 1'b1;
        end
      end
      S_ROWRD: begin
        cur_d = s_rdata;
        idx_d = '0;
      end
      S_ROWWAIT: begin
        if (count_q != '0) begin
          m_rd = 1'b1; m_raddr = {cur_q, VBits'(idx_q)}; rd_pend_d = 1'b1;
        end
      end
      S_SCAN: begin
        // the entry read last cycle is for column idx_q
        if (rd_pend_q) begin
          if (w_pos && !vis_q[VBits'(idx_q)]) begin
            vis_d[VBits'(idx_q)] = 1'b1;
            s_push = 1'b1; s_waddr = VBits'(sp_q); s_wdata = VBits'(idx_q);
            sp_d = sp_q + 1'b1;
          end
          if (idx_q + 1'b1 < count_q) begin
            idx_d = idx_q + 1'b1;
            m_rd = 1'b1; m_raddr = {cur_q, VBits'(idx_q + 1'b1)}; rd_pend_d = 1'b1;
          end
        end
      end
      S_DONE: begin
        rspv_d = 1'b1;
        rsp_d.vertex_total = 5'(count_q);
        case (req_q.operation)
          // phase stays low only when the store was full and no sweep ran
          OP_ADD:          rsp_d.status = phase_q ? ST_OK : ST_FULL;
          OP_SET, OP_CLEAR, OP_QUERY: rsp_d.status = (src_ok && dst_ok) ? ST_OK : ST_RANGE;
          OP_CLEAR_VERTEX: rsp_d.status = src_ok ? ST_OK : ST_RANGE;
          OP_REACH: begin
            rsp_d.status = src_ok ? ST_OK : ST_RANGE;
            if (src_ok) rsp_d.reach_mask = vis16;
          end
          default:         rsp_d.status = ST_RANGE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
    rsp_q <= rsp_d;
    cur_q <= cur_d;
    idx_q <= idx_d;
    phase_q <= phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      sp_q      <= '0;
      vis_q     <= '0;
      rspv_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sp_q      <= sp_d;
      vis_q     <= vis_d;
      rspv_q    <= rspv_d;
      rd_pend_q <= rd_pend_d;
    end
  end

`ifndef SYNTHESIS
  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rspv_q |-> !req_ready_o) else $error("accepted while result pending");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CBits'(MaxVertices)) else $error("vertex count overflow");
  a_stack_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= (VBits+1)'(MaxVertices)) else $error("walk stack overflow");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> rspv_q) else $error("result lost");
`endif
endmodule

### tb/adjacency_matrix_reachability_unit_tb.sv
// adjacency_matrix_reachability_unit_tb: self-checking bench for the graph store and reach walk
// depends on amr_pkg and adjacency_matrix_reachability_unit
`timescale 1ns / 1ps
module adjacency_matrix_reachability_unit_tb;
  import amr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #1 clk = ~clk;

  adjacency_matrix_reachability_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the graph, updated as each transaction is accepted
  logic signed [15:0] graph_w [16][16];
  logic [4:0] graph_vcount = '0;
  logic       graph_directed = 1'b0;

  req_t pending_ops[$];
  rsp_t expected_rsp[$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   want_hold = 1'b0;
  int   gen_vcount = 0;   // vertex count as seen while building the stimulus
  longint cycle_count = 0;

  initial begin
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++) graph_w[i][j] = '0;
  end

  // depth-first walk over positive edges among live vertices
  function automatic logic [15:0] walk_reach(input int start);
    logic [15:0] seen;
    int stk [16];
    int depth;
    int v;
    seen = 16'(1) << start;
    stk[0] = start;
    depth = 1;
    while (depth > 0) begin
      depth--;
      v = stk[depth];
      for (int j = 0; j < graph_vcount; j++) begin
        if (graph_w[v][j] > 0 && !seen[j]) begin
          seen[j] = 1'b1;
          if (depth < 16) begin
            stk[depth] = j;
            depth++;
          end
        end
      end
    end
    return seen;
  endfunction

  // applies one operation to the shadow graph and returns the response it causes
  function automatic rsp_t apply_op(input req_t r);
    rsp_t o;
    logic pair_ok;
    logic src_ok;
    int s;
    int d;
    o = '0;
    s = r.source_vertex;
    d = r.target_vertex;
    src_ok = s < graph_vcount;
    pair_ok = src_ok && d < graph_vcount;
    o.status = ST_OK;
    case (r.operation)
      OP_ADD: begin
        if (graph_vcount >= 16) begin
          o.status = ST_FULL;
        end else begin
          for (int i = 0; i < 16; i++) begin
            graph_w[graph_vcount][i] = '0;
            graph_w[i][graph_vcount] = '0;
          end
          graph_vcount++;
        end
      end
      OP_SET, OP_CLEAR: begin
        if (pair_ok) begin
          graph_w[s][d] = (r.operation == OP_SET) ? r.edge_weight : 16'sd0;
          if (!graph_directed) graph_w[d][s] = graph_w[s][d];
        end else begin
          o.status = ST_RANGE;
        end
      end
      OP_QUERY: begin
        if (pair_ok) begin
          o.weight_read  = graph_w[s][d];
          o.edge_present = graph_w[s][d] != 0;
          o.is_neighbour = graph_w[s][d] > 0;
        end else begin
          o.status = ST_RANGE;
        end
      end
      OP_CLEAR_VERTEX: begin
        if (src_ok) begin
          for (int i = 0; i < 16; i++) begin
            graph_w[s][i] = '0;
            graph_w[i][s] = '0;
          end
        end else begin
          o.status = ST_RANGE;
        end
      end
      OP_REACH: begin
        if (src_ok) o.reach_mask = walk_reach(s);
        else o.status = ST_RANGE;
      end
      default: o.status = ST_RANGE;   // unknown operation codes
    endcase
    o.vertex_total = graph_vcount;
    return o;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // request side: accepted transactions feed the shadow graph
  bit req_taken = 1'b0;
  always @(posedge clk) begin
    req_taken = req_valid && req_ready;
    if (req_taken) expected_rsp.push_back(apply_op(req));
  end

  // driver: new transaction only once the previous one is gone
  always @(negedge clk) begin
    if (rst_n && (!req_valid || req_taken)) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_valid <= 1'b1;
        req <= pending_ops.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the block
  int hold_left = 0;
  bit hold_used = 1'b0;
  always @(negedge clk) begin
    if (want_hold && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: compare every response transaction with the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected response transaction");
        fail_count++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); fail_count++;
        end
        if (rsp.weight_read !== e.weight_read) begin
          $error("weight_read exp %0d got %0d", e.weight_read, rsp.weight_read);
          fail_count++;
        end
        if (rsp.edge_present !== e.edge_present) begin
          $error("edge_present exp %0d got %0d", e.edge_present, rsp.edge_present);
          fail_count++;
        end
        if (rsp.is_neighbour !== e.is_neighbour) begin
          $error("is_neighbour exp %0d got %0d", e.is_neighbour, rsp.is_neighbour);
          fail_count++;
        end
        if (rsp.reach_mask !== e.reach_mask) begin
          $error("reach_mask exp %h got %h", e.reach_mask, rsp.reach_mask); fail_count++;
        end
        if (rsp.vertex_total !== e.vertex_total) begin
          $error("vertex_total exp %0d got %0d", e.vertex_total, rsp.vertex_total);
          fail_count++;
        end
      end
    end
  end

  // queue one operation and keep the stimulus-side vertex count in step
  task automatic queue_op(input logic [2:0] op, input int s, input int d,
                          input logic [15:0] w);
    req_t r;
    r.operation = op;
    r.source_vertex = 4'(s);
    r.target_vertex = 4'(d);
    r.edge_weight = w;
    if (op == OP_ADD && gen_vcount < 16) gen_vcount++;
    pending_ops.push_back(r);
  endtask

  function automatic int pick_vertex();
    if (gen_vcount > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, gen_vcount - 1);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      1: return 16'($urandom);
      2: return 16'h8000 | 16'($urandom_range(0, 32767));
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  task automatic queue_random(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5) queue_op(OP_ADD, $urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom));
      else if (r < 32) queue_op(OP_SET, pick_vertex(), pick_vertex(), pick_weight());
      else if (r < 44) queue_op(OP_CLEAR, pick_vertex(), pick_vertex(), 16'($urandom));
      else if (r < 64) queue_op(OP_QUERY, pick_vertex(), pick_vertex(), 16'($urandom));
      else if (r < 70) queue_op(OP_CLEAR_VERTEX, pick_vertex(), $urandom_range(0, 15), 16'($urandom));
      else if (r < 96) queue_op(OP_REACH, pick_vertex(), $urandom_range(0, 15), 16'($urandom));
      else queue_op(3'($urandom_range(6, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
                    16'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || req_valid || expected_rsp.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write then read back, only while the block is idle
  task automatic apb_write_mode(input logic mode);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegDirected; pwdata <= 32'(mode);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    graph_directed = mode;
    @(negedge clk);
    psel <= 1'b1; paddr <= RegDirected;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== mode) begin
      $error("directed_mode exp %0d got %0d", mode, prdata[0]); fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed: empty graph range errors, extremes, self loop, mirror, unknown codes
    queue_op(OP_REACH, 0, 0, 16'h0);
    queue_op(OP_QUERY, 0, 0, 16'h0);
    queue_op(OP_ADD, 0, 0, 16'h0);
    queue_op(OP_ADD, 15, 15, 16'hffff);
    queue_op(OP_ADD, 0, 0, 16'h0);
    queue_op(OP_SET, 0, 1, 16'h7fff);
    queue_op(OP_QUERY, 1, 0, 16'h0);
    queue_op(OP_SET, 1, 2, 16'h8000);
    queue_op(OP_QUERY, 2, 1, 16'h0);
    queue_op(OP_SET, 2, 2, 16'h0001);
    queue_op(OP_QUERY, 2, 2, 16'h0);
    queue_op(OP_REACH, 0, 0, 16'h0);
    queue_op(OP_SET, 0, 3, 16'h0005);
    queue_op(OP_QUERY, 15, 15, 16'h0);
    queue_op(OP_CLEAR, 1, 0, 16'h0);
    queue_op(OP_REACH, 1, 0, 16'h0);
    queue_op(OP_CLEAR_VERTEX, 2, 0, 16'h0);
    queue_op(OP_CLEAR_VERTEX, 3, 0, 16'h0);
    queue_op(OP_REACH, 15, 0, 16'h0);
    queue_op(3'd6, 0, 0, 16'h0);
    queue_op(3'd7, 15, 15, 16'hffff);
    queue_op(OP_QUERY, 0, 2, 16'h0);
    wait_drained();

    // random phases over idle patterns and both edge modes
    apb_write_mode(1'b1);
    queue_random(450);
    wait_drained();

    send_idle_pct = 65;
    apb_write_mode(1'b0);
    queue_random(450);
    wait_drained();

    send_idle_pct = 0; stall_pct = 65;
    apb_write_mode(1'b1);
    queue_random(450);
    want_hold = 1'b1;   // long hold-off while items keep coming
    wait_drained();

    send_idle_pct = 35; stall_pct = 35;
    apb_write_mode(1'b0);
    queue_random(450);
    wait_drained();
    repeat (600) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
